[hw/rtl/binary_heap_priority_queue_core_macros.svh]
// assertion macros for the binary heap priority queue
`ifndef BINARY_HEAP_PRIORITY_QUEUE_CORE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_CORE_MACROS_SVH

// clocked assertion with synchronous active-low reset as disable
`define BHPQ_ASSERT_CLK(lbl, clk_sig, rstn_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) else $error(msg);

// same on the block clock and reset
`define BHPQ_ASSERT(lbl, prop, msg) `BHPQ_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

[hw/rtl/bhpq_pkg.sv]
// shared command and status codes of the binary heap priority queue
package bhpq_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

[hw/rtl/binary_heap_priority_queue_core.sv]
// top level of the binary heap priority queue: sift sequencer around one heap ram
//
//  channel | direction | handshake        | word
//  in_     | input     | in_valid/stall   | command, value
//  out_    | output    | out_valid/stall  | top_value, is_empty, entry_count, status
//  cfg_    | input     | cfg_valid/ready  | order select bit
//
// peek, refused ops and a pop that empties the heap go straight to the output stage;
// push sifts the new key up from the next free slot towards the root;
// pop moves the last entry to the root and sifts it down;
// each level reads up to two children over the single read port of the heap ram
// synchronous active-low reset clears the count, the order bit and the control state
// a new word is taken only once the previous one has reached the output register;
// a stalled output holds its word while the next operation runs
module binary_heap_priority_queue_core
  import bhpq_pkg::*;
#(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic signed [31:0]  in_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_top_value,
  output logic                out_is_empty,
  output logic [6:0]          out_entry_count,
  output logic [1:0]          out_status,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = KEY_WIDTH;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_UP_RD   = 9'b000000010,
    S_UP_CMP  = 9'b000000100,
    S_DN_LAST = 9'b000001000,
    S_DN_RDL  = 9'b000010000,
    S_DN_RDR  = 9'b000100000,
    S_DN_CMPR = 9'b001000000,
    S_DN_CMP  = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t          state_r, state_nxt;
  status_t         status_r, status_nxt;
  logic [KW-1:0]   key_r, key_nxt;
  logic [KW-1:0]   child_r, child_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [AW-1:0]   cidx_r, cidx_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            order_r;
  logic [KW-1:0]   top_r;

  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_top_r, out_top_nxt;
  logic            out_empty_r, out_empty_nxt;
  logic [6:0]      out_count_r, out_count_nxt;
  logic [1:0]      out_status_r, out_status_nxt;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [KW-1:0]   mem_wdata, mem_rdata;

  logic [KW-1:0]   cmp_a, cmp_b;
  logic            a_beats_b;

  logic [KW+31:0]  in_ext;
  logic [KW-1:0]   in_key;
  logic [AW+1:0]   lft_w, rgt_w, cnt_w;
  logic [AW-1:0]   par_idx;
  logic [KW+31:0]  top_ext;
  logic [CW+6:0]   cnt_ext;
  logic            out_free;

  bhpq_ram #(
    .WIDTH (KW),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ext  = {{KW{in_value[31]}}, in_value};
  assign in_key  = in_ext[KW-1:0];
  assign lft_w   = {1'b0, idx_r, 1'b1};
  assign rgt_w   = lft_w + (AW+2)'(1);
  assign cnt_w   = (AW+2)'(count_r);
  assign par_idx = (idx_r - AW'(1)) >> 1;
  assign top_ext = {32'b0, top_r};
  assign cnt_ext = {7'b0, count_r};
  assign out_free = !out_valid_r || !out_stall;

  // shared key comparator
  always_comb begin
    cmp_a = mem_rdata;
    cmp_b = child_r;
    case (state_r)
      S_UP_CMP: begin
        cmp_a = key_r;
        cmp_b = mem_rdata;
      end
      S_DN_CMP: begin
        cmp_a = child_r;
        cmp_b = key_r;
      end
      default: begin
        cmp_a = mem_rdata;
        cmp_b = child_r;
      end
    endcase
  end

  assign a_beats_b = order_r ? ($signed(cmp_a) < $signed(cmp_b))
                             : ($signed(cmp_a) > $signed(cmp_b));

  always_comb begin
    state_nxt      = state_r;
    status_nxt     = status_r;
    key_nxt        = key_r;
    child_nxt      = child_r;
    idx_nxt        = idx_r;
    cidx_nxt       = cidx_r;
    count_nxt      = count_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = key_r;
    mem_raddr      = par_idx;
    out_valid_nxt  = out_valid_r && out_stall;
    out_top_nxt    = out_top_r;
    out_empty_nxt  = out_empty_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = ST_OK;
          key_nxt    = in_key;
          state_nxt  = S_DONE;
          case (in_command)
            CMD_PUSH: begin
              if (count_r == CW'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                idx_nxt   = AW'(count_r);
                count_nxt = count_r + CW'(1);
                state_nxt = S_UP_RD;
              end
            end
            CMD_POP: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
                mem_raddr = AW'(count_r - CW'(1));
                if (count_r != CW'(1)) begin
                  state_nxt = S_DN_LAST;
                end
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_UP_RD: begin
        if (idx_r == '0) begin
          mem_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          mem_raddr = par_idx;
          cidx_nxt  = par_idx;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (a_beats_b) begin
          mem_wdata = mem_rdata;
          idx_nxt   = cidx_r;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DN_LAST: begin
        key_nxt   = mem_rdata;
        idx_nxt   = '0;
        state_nxt = S_DN_RDL;
      end
      S_DN_RDL: begin
        if (lft_w >= cnt_w) begin
          mem_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          mem_raddr = lft_w[AW-1:0];
          cidx_nxt  = lft_w[AW-1:0];
          state_nxt = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        child_nxt = mem_rdata;
        if (rgt_w < cnt_w) begin
          mem_raddr = rgt_w[AW-1:0];
          state_nxt = S_DN_CMPR;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMPR: begin
        if (a_beats_b) begin
          child_nxt = mem_rdata;
          cidx_nxt  = cidx_r + AW'(1);
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (a_beats_b) begin
          mem_wdata = child_r;
          idx_nxt   = cidx_r;
          state_nxt = S_DN_RDL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_top_nxt    = (count_r == '0) ? 32'b0 : top_ext[31:0];
          out_empty_nxt  = (count_r == '0);
          out_count_nxt  = cnt_ext[6:0];
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      order_r     <= 1'b0;
      out_valid_r <= 1'b0;
      status_r    <= ST_OK;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      if (cfg_valid) begin
        order_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    child_r      <= child_nxt;
    idx_r        <= idx_nxt;
    cidx_r       <= cidx_nxt;
    out_top_r    <= out_top_nxt;
    out_empty_r  <= out_empty_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
    if (mem_we && mem_waddr == '0) begin
      top_r <= mem_wdata;
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_top_value   = out_top_r;
  assign out_is_empty    = out_empty_r;
  assign out_entry_count = out_count_r;
  assign out_status      = out_status_r;

endmodule

[hw/rtl/bhpq_ram.sv]
// generic simple dual-port ram with registered read
module bhpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/bhpq_chk.sv]
// port-level assertion checker for the binary heap priority queue, with its bind
`include "binary_heap_priority_queue_core_macros.svh"

module bhpq_chk
  import bhpq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_top_value,
  input logic        out_is_empty,
  input logic [1:0]  out_status
);

  `BHPQ_ASSERT(a_out_hold, (out_valid && out_stall) |=> out_valid, "stalled word dropped")
  `BHPQ_ASSERT(a_top_hold, (out_valid && out_stall) |=> $stable(out_top_value), "stalled top moved")
  `BHPQ_ASSERT(a_one_at_a_time, (in_valid && !in_stall) |=> in_stall, "word taken mid op")
  `BHPQ_ASSERT(a_empty_top, (out_valid && out_is_empty) |-> (out_top_value == 32'b0), "nonzero top")
  `BHPQ_ASSERT(a_pop_empty, (out_valid && out_status == ST_EMPTY) |-> out_is_empty, "pop fault")

endmodule

bind binary_heap_priority_queue_core bhpq_chk u_bhpq_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_top_value   (out_top_value),
  .out_is_empty    (out_is_empty),
  .out_status      (out_status)
);
